@@ design/wc3_pkg.sv @@
// ----------------------------------------------------------------------------
// wc3_pkg: shared types and constants of the 3x3 window convolution
// Geometry limits, coefficient format, register indexes and payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package wc3_pkg;

    // Geometry
    localparam int MAX_WIDTH    = 1024;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int DIM_W        = 11;

    // Pixels and window
    localparam int PIX_W   = 8;
    localparam int PIX_MAX = 255;
    localparam int KSIZE   = 3;
    localparam int TAP_N   = KSIZE * KSIZE;

    // Coefficients: signed fixed point, three per kernel row register
    localparam int COEF_W         = 16;
    localparam int COEF_FRAC_BITS = 10;
    localparam int KROW_W         = KSIZE * COEF_W;

    // Datapath widths: pixel (zero extended) times coefficient, then sums
    localparam int PROD_W   = PIX_W + 1 + COEF_W;
    localparam int ROWSUM_W = PROD_W + 2;
    localparam int SUM_W    = ROWSUM_W + 2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = KROW_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_KERNEL_TOP   = 3'd2,
        REG_KERNEL_MID   = 3'd3,
        REG_KERNEL_BOT   = 3'd4
    } cfg_reg_t;

    typedef logic [PIX_W-1:0]                 pix_t;
    typedef logic [TAP_N-1:0][PIX_W-1:0]      taps_t;
    typedef logic [KSIZE-1:0][KROW_W-1:0]     kernel_t;

    // Position flags of one item, worked out when it is accepted
    typedef struct packed {
        logic             produce;
        logic             eof;
        logic [KSIZE-1:0] row_ok;
        logic [KSIZE-1:0] col_ok;
    } pos_t;

endpackage

`default_nettype wire

@@ design/wc3_ram.sv @@
// ----------------------------------------------------------------------------
// wc3_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data (read-first).
// ----------------------------------------------------------------------------
`default_nettype none

module wc3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read; a read of the address being written sees old data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ design/wc3_mac.sv @@
// ----------------------------------------------------------------------------
// wc3_mac: multiply-accumulate pipeline of the 3x3 window
// Nine products, three row sums, then total, shift and clamp to 0..255.
// ----------------------------------------------------------------------------
`default_nettype none

module wc3_mac
    import wc3_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  kernel_t kernel,
    input  logic    in_valid,
    output logic    in_ready,
    input  taps_t   in_taps,
    input  logic    in_eof,
    output logic    out_valid,
    input  logic    out_ready,
    output pix_t    out_pixel,
    output logic    out_eof
);

    localparam int SHIFT_W = SUM_W - 1 - COEF_FRAC_BITS;

    logic                       s2_valid_reg;
    logic                       s2_eof_reg;
    logic signed [PROD_W-1:0]   prod_reg [TAP_N];
    logic signed [PROD_W-1:0]   prod_next [TAP_N];

    logic                       s3_valid_reg;
    logic                       s3_eof_reg;
    logic signed [ROWSUM_W-1:0] row_sum_reg [KSIZE];
    logic signed [ROWSUM_W-1:0] row_sum_next [KSIZE];

    logic                       out_valid_reg;
    logic                       out_eof_reg;
    pix_t                       out_pixel_reg;
    pix_t                       out_pixel_next;
    logic signed [SUM_W-1:0]    total;
    logic [SHIFT_W-1:0]         shifted;

    logic                       out_load_ok;
    logic                       s3_load_ok;
    logic                       s2_load_ok;

    // Each stage loads when empty or when its beat moves on
    assign out_load_ok = !out_valid_reg || out_ready;
    assign s3_load_ok  = !s3_valid_reg || out_load_ok;
    assign s2_load_ok  = !s2_valid_reg || s3_load_ok;
    assign in_ready    = s2_load_ok;

    // Nine independent products: zero-extended tap times signed coefficient
    always_comb
    begin
        logic signed [PROD_W-1:0] tap_ext;
        logic signed [PROD_W-1:0] coef_ext;
        for (int i = 0; i < KSIZE; i++)
        begin
            for (int j = 0; j < KSIZE; j++)
            begin
                tap_ext  = PROD_W'($signed({1'b0, in_taps[i*KSIZE + j]}));
                coef_ext = PROD_W'($signed(kernel[i][COEF_W*j +: COEF_W]));
                prod_next[i*KSIZE + j] = tap_ext * coef_ext;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_load_ok)
        begin
            s2_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load_ok && in_valid)
        begin
            s2_eof_reg <= in_eof;
            for (int k = 0; k < TAP_N; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
        end
    end

    // Row sums
    always_comb
    begin
        for (int i = 0; i < KSIZE; i++)
        begin
            row_sum_next[i] = ROWSUM_W'(prod_reg[i*KSIZE])
                            + ROWSUM_W'(prod_reg[i*KSIZE + 1])
                            + ROWSUM_W'(prod_reg[i*KSIZE + 2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_load_ok)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_load_ok && s2_valid_reg)
        begin
            s3_eof_reg <= s2_eof_reg;
            for (int i = 0; i < KSIZE; i++)
            begin
                row_sum_reg[i] <= row_sum_next[i];
            end
        end
    end

    // Total, drop fraction bits, clamp to pixel range
    assign total   = SUM_W'(row_sum_reg[0]) + SUM_W'(row_sum_reg[1])
                   + SUM_W'(row_sum_reg[2]);
    assign shifted = total[SUM_W-2:COEF_FRAC_BITS];

    always_comb
    begin
        if (total[SUM_W-1])
        begin
            out_pixel_next = '0;
        end
        else if (shifted > SHIFT_W'(PIX_MAX))
        begin
            out_pixel_next = PIX_W'(PIX_MAX);
        end
        else
        begin
            out_pixel_next = shifted[PIX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load_ok)
        begin
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load_ok && s3_valid_reg)
        begin
            out_pixel_reg <= out_pixel_next;
            out_eof_reg   <= s3_eof_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign out_eof   = out_eof_reg;

endmodule

`default_nettype wire

@@ design/window_convolution_3x3.sv @@
// ----------------------------------------------------------------------------
// window_convolution_3x3: streaming 3x3 correlation with zero padding
// Two row stores, a 3x3 window and a pipelined multiply-accumulate.
// ----------------------------------------------------------------------------
// Gray pixels enter in raster order and a same-size image leaves, one pixel
// per clock when both sides keep up. Each result is the 3x3 window centred on
// a pixel times the programmed signed Q6.10 kernel (not flipped), with pixels
// outside the frame taken as zero, shifted right by 10 and clamped to 0..255.
// A result leaves frame_width+1 beats after its centre pixel entered, plus
// four pipeline stages (row store read, products, row sums, total and clamp);
// after each frame send frame_width+1 drain beats to flush the last results.
// end_of_frame marks the last pixel of a frame, and the next beat starts a
// new frame. The rate is set by the row stores: one read and one write per
// store per clock. Write frame_width or frame_height only while idle: either
// write restarts the frame. The row stores need no clearing after reset.
`default_nettype none

module window_convolution_3x3
    import wc3_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [PIX_W-1:0]      pixel,
    input  logic                  drain,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIX_W-1:0]      out_pixel,
    output logic                  end_of_frame
);

    // Configuration
    logic [DIM_W-1:0] frame_width_reg;
    logic [DIM_W-1:0] frame_height_reg;
    kernel_t          kernel_reg;
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;

    // Position of the next beat
    logic [COL_W-1:0] col_reg;
    logic [DIM_W-1:0] row_reg;
    logic [COL_W-1:0] col_next;
    logic [DIM_W-1:0] row_next;

    // Accept-side decode
    logic             accept;
    pix_t             acc_pix;
    pos_t             acc_pos;
    logic [DIM_W-1:0] cr;
    logic [DIM_W-1:0] cc;
    logic [DIM_W-1:0] col_ext;

    // Stage 1: row store read data
    logic             s1_valid_reg;
    logic [COL_W-1:0] s1_col_reg;
    pix_t             s1_pix_reg;
    pos_t             s1_pos_reg;
    logic             s1_leave;
    logic             s1_load_ok;
    pix_t             upper_rd;
    pix_t             lower_rd;
    pix_t             upper_col;
    logic             fwd_reg;
    pix_t             fwd_data_reg;

    // Window
    taps_t            taps_reg;
    taps_t            taps_next;
    taps_t            taps_masked;

    logic             mac_ready;

    // Configuration registers; a geometry write restarts the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= DIM_W'(640);
            frame_height_reg <= DIM_W'(480);
            kernel_reg[0]    <= '0;
            kernel_reg[1]    <= KROW_W'(1024);
            kernel_reg[2]    <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[DIM_W-1:0];
                REG_KERNEL_TOP:   kernel_reg[0]    <= cfg_data;
                REG_KERNEL_MID:   kernel_reg[1]    <= cfg_data;
                REG_KERNEL_BOT:   kernel_reg[2]    <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Effective geometry: zero acts as one, clamp to the limits
    always_comb
    begin
        priority if (frame_width_reg == '0)
            w_eff = DIM_W'(1);
        else if (frame_width_reg > DIM_W'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = frame_width_reg;

        priority if (frame_height_reg == '0)
            h_eff = DIM_W'(1);
        else if (frame_height_reg > DIM_W'(HEIGHT_LIMIT))
            h_eff = DIM_W'(HEIGHT_LIMIT);
        else
            h_eff = frame_height_reg;
    end

    // Handshake: stage 1 empties into the MAC, or drops a beat with no result
    assign s1_leave   = s1_valid_reg && (!s1_pos_reg.produce || mac_ready);
    assign s1_load_ok = !s1_valid_reg || s1_leave;
    assign in_ready   = s1_load_ok;
    assign accept     = in_valid && s1_load_ok;
    assign acc_pix    = drain ? '0 : pixel;

    // Decode the window centre and which taps lie inside the frame
    assign col_ext = DIM_W'(col_reg);

    always_comb
    begin
        acc_pos.produce = (row_reg >= DIM_W'(2)) || (row_reg == DIM_W'(1) && col_reg != '0);
        if (col_reg != '0)
        begin
            cr = row_reg - DIM_W'(1);
            cc = col_ext - DIM_W'(1);
        end
        else
        begin
            cr = row_reg - DIM_W'(2);
            cc = w_eff - DIM_W'(1);
        end
        acc_pos.row_ok[0] = (cr != '0) && (cr <= h_eff);
        acc_pos.row_ok[1] = cr < h_eff;
        acc_pos.row_ok[2] = ({1'b0, cr} + (DIM_W+1)'(1)) < {1'b0, h_eff};
        acc_pos.col_ok[0] = cc != '0;
        acc_pos.col_ok[1] = cc < w_eff;
        acc_pos.col_ok[2] = ({1'b0, cc} + (DIM_W+1)'(1)) < {1'b0, w_eff};
        acc_pos.eof       = (cr == h_eff - DIM_W'(1)) && (cc == w_eff - DIM_W'(1));
    end

    // Advance position; wrap at row end, restart after the last result
    always_comb
    begin
        logic [DIM_W-1:0] col_plus;
        col_plus = col_ext + DIM_W'(1);
        priority if (acc_pos.produce && acc_pos.eof)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (col_plus >= w_eff)
        begin
            col_next = '0;
            row_next = row_reg + DIM_W'(1);
        end
        else
        begin
            col_next = col_plus[COL_W-1:0];
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_write && (cfg_reg_t'(cfg_index) == REG_FRAME_WIDTH
                            || cfg_reg_t'(cfg_index) == REG_FRAME_HEIGHT))
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Row stores: lower takes the new pixel, upper takes the old lower entry
    wc3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_lower_ram (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (acc_pix),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (lower_rd)
    );

    wc3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper_ram (
        .clk     (clk),
        .wr_en   (s1_leave),
        .wr_addr (s1_col_reg),
        .wr_data (lower_rd),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (upper_rd)
    );

    // Forward the upper write that lands in the same cycle as a read of its entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (accept)
        begin
            fwd_reg <= s1_leave && (s1_col_reg == col_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwd_data_reg <= lower_rd;
        end
    end

    assign upper_col = fwd_reg ? fwd_data_reg : upper_rd;

    // Stage 1 register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load_ok)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg <= col_reg;
            s1_pix_reg <= acc_pix;
            s1_pos_reg <= acc_pos;
        end
    end

    // Shift the window left and insert the new column
    always_comb
    begin
        for (int i = 0; i < KSIZE; i++)
        begin
            taps_next[i*KSIZE]     = taps_reg[i*KSIZE + 1];
            taps_next[i*KSIZE + 1] = taps_reg[i*KSIZE + 2];
        end
        taps_next[2]           = upper_col;
        taps_next[KSIZE + 2]   = lower_rd;
        taps_next[2*KSIZE + 2] = s1_pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taps_reg <= '0;
        end
        else if (s1_leave)
        begin
            taps_reg <= taps_next;
        end
    end

    // Zero taps that fall outside the frame
    always_comb
    begin
        for (int i = 0; i < KSIZE; i++)
        begin
            for (int j = 0; j < KSIZE; j++)
            begin
                taps_masked[i*KSIZE + j] = (s1_pos_reg.row_ok[i] && s1_pos_reg.col_ok[j])
                                         ? taps_next[i*KSIZE + j] : '0;
            end
        end
    end

    wc3_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .kernel    (kernel_reg),
        .in_valid  (s1_valid_reg && s1_pos_reg.produce),
        .in_ready  (mac_ready),
        .in_taps   (taps_masked),
        .in_eof    (s1_pos_reg.eof),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_pixel (out_pixel),
        .out_eof   (end_of_frame)
    );

`ifndef SYNTHESIS
    // Column position stays inside the row
    ap_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        col_ext < w_eff)
        else $error("column position beyond frame width");

    // Rows never run past the drain rows of the frame
    ap_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, row_reg} <= ({1'b0, h_eff} + (DIM_W+1)'(1))))
        else $error("row position beyond frame plus drain");

    // The beat that gives the last result of a frame restarts the position
    ap_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && acc_pos.produce && acc_pos.eof && !cfg_write)
        |=> (col_reg == '0 && row_reg == '0))
        else $error("position not cleared after frame end");
`endif

endmodule

`default_nettype wire

@@ sim/window_convolution_3x3_tb.sv @@
// ----------------------------------------------------------------------------
// window_convolution_3x3_tb: self-checking bench of the 3x3 window convolution
// Streams gray frames through the block under random stalls on both sides,
// predicts every filtered pixel with a behavioral copy of the window logic
// and compares each output beat, pixel and frame-end flag, in order.
// ----------------------------------------------------------------------------
module window_convolution_3x3_tb;
    import wc3_pkg::*;

    localparam int unsigned RANDOM_BEATS   = 680;
    localparam int unsigned TALL_BEATS     = 200;
    localparam int unsigned SETTLE_CYCLES  = 16;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DIM_MAX        = (1 << DIM_W) - 1;
    localparam logic [COEF_W-1:0] COEF_POS_MAX = 16'h7FFF;
    localparam logic [COEF_W-1:0] COEF_NEG_MAX = 16'h8000;

    typedef struct packed {
        pix_t value;
        logic eof;
    } filtered_t;

    // DUT ports
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [PIX_W-1:0]      pixel     = '0;
    logic                  drain     = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [PIX_W-1:0]      out_pixel;
    logic                  end_of_frame;

    // Image model: registers, row stores, window and scan position
    logic [DIM_W-1:0]  frame_w_reg = DIM_W'(640);
    logic [DIM_W-1:0]  frame_h_reg = DIM_W'(480);
    logic [KROW_W-1:0] kernel_reg [KSIZE] = '{'0, KROW_W'(1) << COEF_FRAC_BITS, '0};
    pix_t              line_upper [MAX_WIDTH] = '{default: '0};
    pix_t              line_lower [MAX_WIDTH] = '{default: '0};
    pix_t              win [TAP_N] = '{default: '0};
    int                scan_col = 0;
    int                scan_row = 0;

    filtered_t   pending_pixels [$];
    bit          steady_flow    = 1'b0;
    int unsigned ready_hold     = 0;
    int unsigned error_count    = 0;
    int unsigned beats_sent     = 0;
    int unsigned pixels_checked = 0;
    int unsigned frames_sent    = 0;
    int unsigned reg_writes     = 0;

    window_convolution_3x3 u_top (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle length: mostly none, some short, a few long
    function automatic int unsigned idle_gap();
        int unsigned roll;
        if (steady_flow)
            return 0;
        roll = $urandom_range(0, 19);
        if (roll < 14)
            return 0;
        if (roll < 19)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic pix_t rand_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return pix_t'(PIX_MAX);
            default: return pix_t'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_word();
        return CFG_DATA_W'({$urandom, $urandom});
    endfunction

    // Coefficients: mostly within +-1.0, some full range, some at the extremes
    function automatic logic [COEF_W-1:0] rand_coef();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 3))
                    0:       return COEF_POS_MAX;
                    1:       return COEF_NEG_MAX;
                    2:       return '1;
                    default: return '0;
                endcase
            end
            1:       return COEF_W'($urandom);
            default: return COEF_W'($urandom_range(0, 2048) - 1024);
        endcase
    endfunction

    function automatic logic [KROW_W-1:0] rand_kernel_row();
        return {rand_coef(), rand_coef(), rand_coef()};
    endfunction

    // Advance the image model by one accepted beat and queue its output pixel
    task automatic predict_filtered(input pix_t pix, input logic drn);
        int        w, h, col, row, cr, cc;
        longint    acc;
        shortint   coef;
        pix_t      v;
        filtered_t item;
        w = (frame_w_reg == 0) ? 1 : (frame_w_reg > MAX_WIDTH) ? MAX_WIDTH : int'(frame_w_reg);
        h = (frame_h_reg == 0) ? 1 : (frame_h_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT
                                                                  : int'(frame_h_reg);
        v = drn ? '0 : pix;
        col = scan_col % MAX_WIDTH;
        row = scan_row;

        // slide the window left and load the new column
        for (int r = 0; r < KSIZE; r++)
        begin
            win[r*KSIZE]     = win[r*KSIZE + 1];
            win[r*KSIZE + 1] = win[r*KSIZE + 2];
        end
        win[KSIZE-1]   = line_upper[col];
        win[2*KSIZE-1] = line_lower[col];
        win[3*KSIZE-1] = v;
        line_upper[col] = line_lower[col];
        line_lower[col] = v;

        if (row >= 2 || (row == 1 && col >= 1))
        begin
            if (col >= 1)
            begin
                cr = row - 1;
                cc = col - 1;
            end
            else
            begin
                cr = row - 2;
                cc = w - 1;
            end
            // sum the taps that fall inside the frame
            acc = 0;
            for (int r = 0; r < KSIZE; r++)
                for (int c = 0; c < KSIZE; c++)
                    if (cr - 1 + r >= 0 && cr - 1 + r < h && cc - 1 + c >= 0 && cc - 1 + c < w)
                    begin
                        coef = kernel_reg[r][COEF_W*c +: COEF_W];
                        acc += coef * int'(win[r*KSIZE + c]);
                    end
            if (acc < 0)
                item.value = '0;
            else if ((acc >>> COEF_FRAC_BITS) > PIX_MAX)
                item.value = pix_t'(PIX_MAX);
            else
                item.value = pix_t'(acc >>> COEF_FRAC_BITS);
            item.eof = (cr == h - 1) && (cc == w - 1);
            pending_pixels.insert(pending_pixels.size(), item);
            if (item.eof)
            begin
                scan_col = 0;
                scan_row = 0;
                return;
            end
        end

        scan_col = col + 1;
        if (scan_col >= w)
        begin
            scan_col = 0;
            scan_row = (scan_row + 1) % (1 << DIM_W);
        end
    endtask

    // Write one register and mirror it in the model
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:
            begin
                frame_w_reg = data[DIM_W-1:0];
                scan_col = 0;
                scan_row = 0;
            end
            REG_FRAME_HEIGHT:
            begin
                frame_h_reg = data[DIM_W-1:0];
                scan_col = 0;
                scan_row = 0;
            end
            REG_KERNEL_TOP: kernel_reg[0] = data;
            REG_KERNEL_MID: kernel_reg[1] = data;
            REG_KERNEL_BOT: kernel_reg[2] = data;
            default: ;
        endcase
        reg_writes++;
        @(posedge clk);
    endtask

    // Geometry writes carry random bits above the field
    task automatic set_geometry(input int unsigned w, input int unsigned h);
        logic [CFG_DATA_W-1:0] noise;
        noise = rand_word();
        write_reg(REG_FRAME_WIDTH, {noise[CFG_DATA_W-1:DIM_W], DIM_W'(w)});
        noise = rand_word();
        write_reg(REG_FRAME_HEIGHT, {noise[CFG_DATA_W-1:DIM_W], DIM_W'(h)});
    endtask

    task automatic set_kernel(input logic [KROW_W-1:0] top, input logic [KROW_W-1:0] mid,
                              input logic [KROW_W-1:0] bot);
        write_reg(REG_KERNEL_TOP, top);
        write_reg(REG_KERNEL_MID, mid);
        write_reg(REG_KERNEL_BOT, bot);
    endtask

    // Send one input beat after a random gap; hold valid until accepted
    task automatic send_item(input pix_t pix, input logic drn);
        int unsigned gap;
        gap = idle_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= pix;
        drain    <= drn;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        predict_filtered(pix, drn);
        beats_sent++;
    endtask

    // One frame of random pixels, then the flush beats; drain phase mixes in pixels
    task automatic send_frame(input int unsigned w, input int unsigned h,
                              input int unsigned noise_pct);
        for (int unsigned n = 0; n < w * h; n++)
            send_item(rand_pixel(), $urandom_range(0, 99) < noise_pct);
        for (int unsigned n = 0; n <= w; n++)
            send_item(rand_pixel(), $urandom_range(0, 4) != 0);
        frames_sent++;
    endtask

    // Drop valid, wait for every expected pixel, then let the pipeline empty
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Reset kernel (left tap at 1.0) on a 4x3 frame: pixel extremes, drain in frame
    task automatic test_directed_frame();
        set_geometry(4, 3);
        for (int k = 0; k < 12; k++)
            send_item((k == 0) ? pix_t'(0) : (k == 1) ? pix_t'(PIX_MAX) : rand_pixel(), k == 6);
        for (int k = 0; k < 5; k++)
            send_item((k == 0) ? pix_t'(PIX_MAX) : rand_pixel(), (k % 2) == 0);
        frames_sent++;
        settle();
    endtask

    // Largest positive and negative coefficients: clamp high and clamp low
    task automatic test_kernel_extremes();
        set_geometry(2, 1);
        set_kernel({KSIZE{COEF_POS_MAX}}, {KSIZE{COEF_POS_MAX}}, {KSIZE{COEF_POS_MAX}});
        send_frame(2, 1, 0);
        settle();
        set_kernel({KSIZE{COEF_NEG_MAX}}, {KSIZE{COEF_NEG_MAX}}, {KSIZE{COEF_NEG_MAX}});
        send_frame(2, 1, 0);
        settle();
    endtask

    // Writes to unused indexes must leave geometry and kernel alone
    task automatic test_register_index_range();
        set_geometry(3, 2);
        set_kernel(rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
        for (int k = int'(REG_KERNEL_BOT) + 1; k < (1 << CFG_IDX_W); k++)
            write_reg(CFG_IDX_W'(k), rand_word());
        send_frame(3, 2, 0);
        settle();
    endtask

    // Zero geometry acts as one pixel; an over-range height streams many rows
    // back to back without an early frame end
    task automatic test_geometry_extremes();
        set_kernel(rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
        set_geometry(0, 0);
        send_frame(1, 1, 0);
        settle();
        steady_flow = 1'b1;
        set_geometry(1, DIM_MAX);
        repeat (TALL_BEATS) send_item(rand_pixel(), $urandom_range(0, 49) == 0);
        settle();
        steady_flow = 1'b0;
    endtask

    // Small random frames: mostly complete, some with trailing beats or cut short
    task automatic test_random_frames();
        int unsigned start, w, h, style;
        start = beats_sent;
        while (beats_sent - start < RANDOM_BEATS)
        begin
            steady_flow = ($urandom_range(0, 4) == 0);
            w = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            h = (w > 8) ? $urandom_range(1, 3) : $urandom_range(1, 6);
            set_geometry(w, h);
            for (int k = 0; k < KSIZE; k++)
                if ($urandom_range(0, 2) != 0)
                    write_reg(CFG_IDX_W'(int'(REG_KERNEL_TOP) + k), rand_kernel_row());
            style = $urandom_range(0, 9);
            if (style < 7)
                repeat ($urandom_range(1, 2)) send_frame(w, h, 3);
            else if (style < 9)
            begin
                send_frame(w, h, 10);
                repeat ($urandom_range(1, w * h)) send_item(rand_pixel(), $urandom_range(0, 1));
            end
            else
                repeat ($urandom_range(1, w * h + w)) send_item(rand_pixel(), $urandom_range(0, 1));
            settle();
        end
        steady_flow = 1'b0;
    endtask

    // Receiver: random stalls on out_ready
    always @(posedge clk)
    begin : out_ready_drive
        int unsigned stall;
        stall = idle_gap();
        if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else if (out_ready && stall != 0)
        begin
            out_ready  <= 1'b0;
            ready_hold <= stall - 1;
        end
        else
            out_ready <= 1'b1;
    end

    // Compare each output beat against the oldest expected pixel
    always @(posedge clk)
    begin : check_results
        filtered_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected output beat: out_pixel %0d end_of_frame %0b",
                       out_pixel, end_of_frame);
                error_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (out_pixel !== want.value)
                begin
                    $error("out_pixel: expected %0d, actual %0d", want.value, out_pixel);
                    error_count++;
                end
                if (end_of_frame !== want.eof)
                begin
                    $error("end_of_frame: expected %0b, actual %0b", want.eof, end_of_frame);
                    error_count++;
                end
                pixels_checked++;
            end
        end
    end

    // End the run when no beat moves for too long
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no beat for %0d cycles, %0d pixels outstanding",
                 WATCHDOG_LIMIT, pending_pixels.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : run
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frame();
        test_kernel_extremes();
        test_register_index_range();
        test_geometry_extremes();
        test_random_frames();
        settle();

        if (pending_pixels.size() != 0)
        begin
            $error("%0d expected pixels never arrived", pending_pixels.size());
            error_count++;
        end
        $display("Sent %0d input beats in %0d frames with %0d register writes,",
                 beats_sent, frames_sent, reg_writes);
        $display("checked %0d filtered pixels; %0d mismatches.", pixels_checked, error_count);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
